@@ rtl/chte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// Types and constants shared by the chained hash table engine modules.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int KEY_W         = 64;
    localparam int VAL_W         = 32;
    localparam int CNT_W         = 11;
    localparam int CFG_W         = 10;
    localparam int SUM_W         = 11;
    localparam int DIV_CNT_W     = 4;
    localparam int RESET_BUCKETS = 509;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_DUP    = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_HEAD_WAIT,
        S_WALK,
        S_CMP,
        S_FREE_WAIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    clear_wr;
        logic    load;
        logic    div_step;
        logic    head_rd;
        logic    head_take;
        logic    node_rd;
        logic    advance;
        logic    free_rd;
        logic    insert_wr;
        logic    remove_wr;
        logic    res_we;
        status_t res_status;
        logic    res_found;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic cur_null;
        logic key_match;
        logic pool_full;
        op_t  op;
    } sts_t;

endpackage

@@ rtl/chte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_if
// Valid/ready channels of the engine: request, response and configuration.
// ----------------------------------------------------------------------------
interface chte_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [chte_pkg::KEY_W-1:0] key;
    logic [chte_pkg::VAL_W-1:0] value;

    modport source (output valid, op, key, value, input ready);
    modport sink   (input valid, op, key, value, output ready);
endinterface

interface chte_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [chte_pkg::VAL_W-1:0] found_value;
    logic [chte_pkg::CNT_W-1:0] entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

interface chte_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [chte_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/chained_hash_table_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Exact-match key/value table with chained buckets and a pooled entry store.
// ----------------------------------------------------------------------------
// After reset every bucket head is cleared first; no request is taken
// meanwhile, configuration writes are.
// The byte sum of the key is reduced modulo the bucket count to pick the
// chain; the unused op code responds without walking it.
// One request is handled at a time; the next is taken in the cycle after the
// response register is loaded.
module chained_hash_table_engine #(
    parameter int KEY_BYTES  = 8,
    parameter int BUCKETS    = 512,
    parameter int ENTRIES    = 1024,
    parameter int VALUE_BITS = 32
) (
    input logic         clk,
    input logic         rst_n,
    chte_req_if.sink    req,
    chte_rsp_if.source  rsp,
    chte_cfg_if.sink    cfg
);

    chte_pkg::cmd_t cmd;
    chte_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    chte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chte_datapath #(
        .KEY_BYTES  (KEY_BYTES),
        .BUCKETS    (BUCKETS),
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg.valid),
        .cfg_data        (cfg.data),
        .req_op          (req.op),
        .req_key         (req.key),
        .req_value       (req.value),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_status      (rsp.status),
        .rsp_found_value (rsp.found_value),
        .rsp_entry_count (rsp.entry_count)
    );

`ifndef NO_ASSERTIONS
    // Only a successful lookup returns a nonzero value.
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found_value != '0 |-> rsp.status == chte_pkg::STAT_DONE)
        else $error("found value with non-done status");

    // The table updates never overlap the clearing pass or each other.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert_wr |-> !cmd.remove_wr && !cmd.clear_wr)
        else $error("conflicting table writes");

    // Table full is reported only when the pool is exhausted.
    a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_we && cmd.res_status == chte_pkg::STAT_FULL |-> sts.pool_full)
        else $error("full reported with free entries");
`endif

endmodule

@@ rtl/chte_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ctrl
// Controller state machine: sequences hashing, chain walk and table updates.
// ----------------------------------------------------------------------------
module chte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  chte_pkg::sts_t  sts,
    output chte_pkg::cmd_t  cmd
);

    chte_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chte_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chte_pkg::S_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = chte_pkg::S_IDLE;
            end
            chte_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = chte_pkg::S_DIV;
            end
            chte_pkg::S_DIV:
            begin
                if (sts.div_last)
                    state_next = (sts.op == chte_pkg::OP_NOP) ? chte_pkg::S_RESULT
                                                                : chte_pkg::S_HEAD;
            end
            chte_pkg::S_HEAD:      state_next = chte_pkg::S_HEAD_WAIT;
            chte_pkg::S_HEAD_WAIT: state_next = chte_pkg::S_WALK;
            chte_pkg::S_WALK:
            begin
                if (!sts.cur_null)
                    state_next = chte_pkg::S_CMP;
                else if (sts.op == chte_pkg::OP_INSERT && !sts.pool_full)
                    state_next = chte_pkg::S_FREE_WAIT;
                else
                    state_next = chte_pkg::S_RESULT;
            end
            chte_pkg::S_CMP:
            begin
                state_next = sts.key_match ? chte_pkg::S_RESULT : chte_pkg::S_WALK;
            end
            chte_pkg::S_FREE_WAIT: state_next = chte_pkg::S_RESULT;
            chte_pkg::S_RESULT:
            begin
                if (!out_valid_reg || rsp_ready)
                    state_next = chte_pkg::S_IDLE;
            end
            default: state_next = chte_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.res_status = chte_pkg::STAT_DONE;
        case (state_reg)
            chte_pkg::S_CLEAR: cmd.clear_wr = 1'b1;
            chte_pkg::S_IDLE:  cmd.load = req_valid;
            chte_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last && sts.op == chte_pkg::OP_NOP)
                    cmd.res_we = 1'b1;
            end
            chte_pkg::S_HEAD:      cmd.head_rd = 1'b1;
            chte_pkg::S_HEAD_WAIT: cmd.head_take = 1'b1;
            chte_pkg::S_WALK:
            begin
                if (!sts.cur_null)
                    cmd.node_rd = 1'b1;
                else if (sts.op == chte_pkg::OP_INSERT && !sts.pool_full)
                    cmd.free_rd = 1'b1;
                else
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = (sts.op == chte_pkg::OP_INSERT) ? chte_pkg::STAT_FULL
                                                                      : chte_pkg::STAT_ABSENT;
                end
            end
            chte_pkg::S_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.res_we = 1'b1;
                    case (sts.op)
                        chte_pkg::OP_INSERT: cmd.res_status = chte_pkg::STAT_DUP;
                        chte_pkg::OP_LOOKUP: cmd.res_found = 1'b1;
                        chte_pkg::OP_REMOVE: cmd.remove_wr = 1'b1;
                        default:             cmd.res_status = chte_pkg::STAT_DONE;
                    endcase
                end
                else
                    cmd.advance = 1'b1;
            end
            chte_pkg::S_FREE_WAIT:
            begin
                cmd.insert_wr = 1'b1;
                cmd.res_we    = 1'b1;
            end
            chte_pkg::S_RESULT: cmd.out_load = !out_valid_reg || rsp_ready;
            default: cmd = '0;
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & ~rsp_ready);
    assign req_ready      = (state_reg == chte_pkg::S_IDLE);
    assign rsp_valid      = out_valid_reg;

endmodule

@@ rtl/chte_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_datapath
// Hash unit, table memories, free stack and result registers.
// ----------------------------------------------------------------------------
module chte_datapath #(
    parameter int KEY_BYTES  = 8,
    parameter int BUCKETS    = 512,
    parameter int ENTRIES    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [chte_pkg::CFG_W-1:0] cfg_data,
    input  logic [1:0]                 req_op,
    input  logic [chte_pkg::KEY_W-1:0] req_key,
    input  logic [chte_pkg::VAL_W-1:0] req_value,
    input  chte_pkg::cmd_t             cmd,
    output chte_pkg::sts_t             sts,
    output logic [1:0]                 rsp_status,
    output logic [chte_pkg::VAL_W-1:0] rsp_found_value,
    output logic [chte_pkg::CNT_W-1:0] rsp_entry_count
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int PW    = IW + 1;
    localparam int BW    = $clog2(BUCKETS);
    localparam int VW    = (VALUE_BITS > chte_pkg::VAL_W) ? chte_pkg::VAL_W : VALUE_BITS;
    localparam int KW    = 8 * KEY_BYTES;
    localparam int BCAP  = (BUCKETS > 1023) ? 1023 : BUCKETS;
    localparam int DW    = chte_pkg::SUM_W + chte_pkg::CFG_W;
    localparam logic [PW-1:0] NO_ENTRY = PW'(ENTRIES);

    logic [PW-1:0]  bucket_head [BUCKETS];
    logic [KW-1:0]  node_key    [ENTRIES];
    logic [VW-1:0]  node_value  [ENTRIES];
    logic [PW-1:0]  node_link   [ENTRIES];
    logic [IW-1:0]  free_pool   [ENTRIES];

    logic [chte_pkg::CFG_W-1:0]     cfg_reg;
    logic [BW-1:0]                  clr_reg;
    chte_pkg::op_t                  op_reg;
    logic [KW-1:0]                  key_reg;
    logic [VW-1:0]                  value_reg;
    logic [chte_pkg::SUM_W-1:0]     rem_reg;
    logic [chte_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [PW-1:0]                  head_rd_reg, head_save_reg;
    logic [PW-1:0]                  cur_reg, prev_reg;
    logic [KW-1:0]                  key_rd_reg;
    logic [VW-1:0]                  value_rd_reg;
    logic [PW-1:0]                  link_rd_reg;
    logic [IW-1:0]                  free_rd_reg, pos_alloc_reg;
    logic                           use_stack_reg;
    logic [PW-1:0]                  bindings_reg, max_reg;
    chte_pkg::status_t              res_status_reg;
    logic [VW-1:0]                  res_found_reg;
    logic [1:0]                     out_status_reg;
    logic [chte_pkg::VAL_W-1:0]     out_found_reg;
    logic [chte_pkg::CNT_W-1:0]     out_count_reg;

    logic [KW-1:0]                  key_in;
    logic [chte_pkg::SUM_W-1:0]     byte_sum;
    logic [chte_pkg::CFG_W-1:0]     modulus;
    logic [DW-1:0]                  divisor;
    logic [BW-1:0]                  bucket;
    logic [IW-1:0]                  cur_idx, prev_idx, slot_idx, pos_alloc, pos_push;
    logic [PW-1:0]                  bindings_inc;
    logic                           prev_null;
    logic                           bh_we, lk_we;
    logic [BW-1:0]                  bh_addr;
    logic [PW-1:0]                  bh_wdata, lk_wdata;
    logic [IW-1:0]                  lk_addr;

    always_comb
    begin
        key_in   = req_key[KW-1:0];
        byte_sum = '0;
        for (int i = 0; i < KEY_BYTES; i++)
            byte_sum = byte_sum + chte_pkg::SUM_W'(key_in[8*i +: 8]);
    end

    // A zero count acts as one bucket; counts above the table size saturate.
    always_comb
    begin
        if (cfg_reg == '0)
            modulus = chte_pkg::CFG_W'(1);
        else if (cfg_reg > chte_pkg::CFG_W'(BCAP))
            modulus = chte_pkg::CFG_W'(BCAP);
        else
            modulus = cfg_reg;
    end

    assign divisor      = DW'(modulus) << div_cnt_reg;
    assign bucket       = BW'(rem_reg);
    assign cur_idx      = cur_reg[IW-1:0];
    assign prev_idx     = prev_reg[IW-1:0];
    assign prev_null    = (prev_reg >= NO_ENTRY);
    assign slot_idx     = use_stack_reg ? free_rd_reg : pos_alloc_reg;
    assign pos_alloc    = IW'(PW'(ENTRIES - 1) - bindings_reg);
    assign pos_push     = IW'(NO_ENTRY - bindings_reg);
    assign bindings_inc = bindings_reg + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= chte_pkg::CFG_W'(chte_pkg::RESET_BUCKETS);
            clr_reg      <= '0;
            bindings_reg <= '0;
            max_reg      <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                cfg_reg <= cfg_data;
            if (cmd.clear_wr)
                clr_reg <= clr_reg + BW'(1);
            if (cmd.load)
                div_cnt_reg <= chte_pkg::DIV_CNT_W'(chte_pkg::SUM_W - 1);
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - chte_pkg::DIV_CNT_W'(1);
            if (cmd.insert_wr)
            begin
                bindings_reg <= bindings_inc;
                if (bindings_inc > max_reg)
                    max_reg <= bindings_inc;
            end
            else if (cmd.remove_wr)
                bindings_reg <= bindings_reg - PW'(1);
        end
    end

    // Restoring reduction of the byte sum, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= chte_pkg::op_t'(req_op);
            key_reg   <= key_in;
            value_reg <= req_value[VW-1:0];
            rem_reg   <= byte_sum;
        end
        else if (cmd.div_step && DW'(rem_reg) >= divisor)
            rem_reg <= rem_reg - divisor[chte_pkg::SUM_W-1:0];

        if (cmd.head_take)
        begin
            cur_reg       <= head_rd_reg;
            head_save_reg <= head_rd_reg;
            prev_reg      <= NO_ENTRY;
        end
        else if (cmd.advance)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= link_rd_reg;
        end

        if (cmd.free_rd)
        begin
            pos_alloc_reg <= pos_alloc;
            use_stack_reg <= (bindings_reg < max_reg);
        end

        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found ? value_rd_reg : '0;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= chte_pkg::VAL_W'(res_found_reg);
            out_count_reg  <= chte_pkg::CNT_W'(bindings_reg);
        end
    end

    assign bh_we    = cmd.clear_wr | cmd.insert_wr | (cmd.remove_wr & prev_null);
    assign bh_addr  = cmd.clear_wr ? clr_reg : bucket;
    assign bh_wdata = cmd.clear_wr  ? NO_ENTRY :
                      cmd.insert_wr ? PW'(slot_idx) : link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (bh_we)
            bucket_head[bh_addr] <= bh_wdata;
        if (cmd.head_rd)
            head_rd_reg <= bucket_head[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert_wr)
            node_key[slot_idx] <= key_reg;
        if (cmd.node_rd)
            key_rd_reg <= node_key[cur_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert_wr)
            node_value[slot_idx] <= value_reg;
        if (cmd.node_rd)
            value_rd_reg <= node_value[cur_idx];
    end

    assign lk_we    = cmd.insert_wr | (cmd.remove_wr & ~prev_null);
    assign lk_addr  = cmd.insert_wr ? slot_idx : prev_idx;
    assign lk_wdata = cmd.insert_wr ? head_save_reg : link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (lk_we)
            node_link[lk_addr] <= lk_wdata;
        if (cmd.node_rd)
            link_rd_reg <= node_link[cur_idx];
    end

    // A stack slot's value is used only once a remove has pushed there; before
    // that the slot's own position is allocated instead of the stack value.
    always_ff @(posedge clk)
    begin
        if (cmd.remove_wr)
            free_pool[pos_push] <= cur_idx;
        if (cmd.free_rd)
            free_rd_reg <= free_pool[pos_alloc];
    end

    always_comb
    begin
        sts            = '0;
        sts.clear_last = (clr_reg == BW'(BUCKETS - 1));
        sts.div_last   = (div_cnt_reg == '0);
        sts.cur_null   = (cur_reg >= NO_ENTRY);
        sts.key_match  = (key_rd_reg == key_reg);
        sts.pool_full  = (bindings_reg >= NO_ENTRY);
        sts.op         = op_reg;
    end

    assign rsp_status      = out_status_reg;
    assign rsp_found_value = out_found_reg;
    assign rsp_entry_count = out_count_reg;

endmodule

@@ tb/sv/tb_chte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chte_if
// Table sizes shared by the testbench; the channel interfaces themselves
// come from the RTL interface file.
// ----------------------------------------------------------------------------
package tb_chte_names;
    localparam int NENT = 1024;
    localparam int NBKT = 512;
endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: chained hash table engine
// Drives insert, lookup, remove and no-op words through the request channel
// under several bucket counts. A behavioral table (bucket chains, entry pool,
// free stack) predicts every response. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int NENT  = tb_chte_names::NENT;
    localparam int NBKT  = tb_chte_names::NBKT;
    localparam int LIMIT = 10000000;

    typedef struct packed {
        chte_pkg::status_t status;
        logic [31:0]       found;
        logic [10:0]       count;
    } rsp_t;

    typedef struct {
        chte_pkg::op_t op;
        logic [63:0]   key;
        logic [31:0]   value;
        logic          typed;
        rsp_t          want;
    } row_t;

    logic clk;
    logic rst_n;

    chte_req_if req ();
    chte_rsp_if rsp ();
    chte_cfg_if cfg ();

    chained_hash_table_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Predicted table state.
    int unsigned   head_of[NBKT];
    logic [63:0]   ent_key[NENT];
    logic [31:0]   ent_val[NENT];
    int unsigned   ent_next[NENT];
    int unsigned   free_stack[NENT];
    int unsigned   held;
    logic [9:0]    buckets;

    rsp_t          pending[$];
    logic [63:0]   live_keys[$];
    int            errors;
    int            checked;
    int            cycles;
    bit            rsp_hold;
    int            n_full, n_dup, n_absent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic void table_clear();
        for (int i = 0; i < NBKT; i++) head_of[i] = NENT;
        for (int i = 0; i < NENT; i++)
        begin
            ent_next[i] = NENT;
            free_stack[i] = i;
        end
        held = 0;
        buckets = 10'(chte_pkg::RESET_BUCKETS);
    endfunction

    function automatic int unsigned bucket_for(logic [63:0] k);
        int unsigned sum;
        int unsigned n;
        sum = 0;
        for (int i = 0; i < 8; i++) sum += k[8*i +: 8];
        n = buckets;
        if (n == 0) n = 1;
        if (n > NBKT) n = NBKT;
        return sum % n;
    endfunction

    function automatic rsp_t table_apply(chte_pkg::op_t op, logic [63:0] k,
                                         logic [31:0] v);
        rsp_t r;
        int unsigned b, cur, prev, hit, slot, steps;
        r = '0;
        if (op != chte_pkg::OP_NOP)
        begin
            b = bucket_for(k);
            cur = head_of[b];
            prev = NENT;
            hit = NENT;
            steps = 0;
            while (cur < NENT && steps < NENT)
            begin
                if (ent_key[cur] == k)
                begin
                    hit = cur;
                    break;
                end
                prev = cur;
                cur = ent_next[cur];
                steps++;
            end
            if (op == chte_pkg::OP_INSERT)
            begin
                if (hit < NENT) r.status = chte_pkg::STAT_DUP;
                else if (held >= NENT) r.status = chte_pkg::STAT_FULL;
                else
                begin
                    slot = free_stack[NENT - 1 - held];
                    ent_key[slot] = k;
                    ent_val[slot] = v;
                    ent_next[slot] = head_of[b];
                    head_of[b] = slot;
                    held++;
                end
            end
            else if (hit >= NENT) r.status = chte_pkg::STAT_ABSENT;
            else if (op == chte_pkg::OP_LOOKUP) r.found = ent_val[hit];
            else
            begin
                if (prev < NENT) ent_next[prev] = ent_next[hit];
                else head_of[b] = ent_next[hit];
                held--;
                free_stack[NENT - 1 - held] = hit;
            end
        end
        r.count = 11'(held);
        return r;
    endfunction

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g != 0) req.valid <= 1'b0;
        repeat (g) @(posedge clk);
    endtask

    // Leaves valid high after the accepting edge; the caller either offers
    // the next word at once or drops valid through a gap or a drain.
    task automatic send_word(chte_pkg::op_t op, logic [63:0] k, logic [31:0] v,
                             rsp_t want, bit typed);
        rsp_t p;
        p = table_apply(op, k, v);
        if (typed && p != want)
        begin
            errors++;
            if (errors <= 10)
                $display("table entry mismatch: expected %h, model gives %h", want, p);
        end
        case (p.status)
            chte_pkg::STAT_FULL:   n_full++;
            chte_pkg::STAT_DUP:    n_dup++;
            chte_pkg::STAT_ABSENT: n_absent++;
            default: ;
        endcase
        if (op == chte_pkg::OP_INSERT && p.status == chte_pkg::STAT_DONE)
            live_keys.push_back(k);
        pending.push_back(p);
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= k;
        req.value <= v;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_buckets(logic [9:0] n);
        cfg.valid <= 1'b1;
        cfg.data  <= n;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        buckets = n;
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: k = k & 64'hFF;
            1: k = k & 64'hFFFF_0000_0000_0003;
            default: ;
        endcase
        return k;
    endfunction

    task automatic random_words(int n, int keyspace);
        chte_pkg::op_t op;
        logic [63:0]   k;
        int            pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40) op = chte_pkg::OP_INSERT;
            else if (pick < 70) op = chte_pkg::OP_LOOKUP;
            else if (pick < 97) op = chte_pkg::OP_REMOVE;
            else op = chte_pkg::OP_NOP;
            if (live_keys.size() != 0 && $urandom_range(0, 99) < 60)
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if (keyspace != 0)
                k = 64'($urandom_range(0, keyspace)) << ($urandom_range(0, 7) * 8);
            else
                k = rand_key();
            send_word(op, k, $urandom, '0, 1'b0);
            if (op == chte_pkg::OP_REMOVE && live_keys.size() > 64) live_keys.delete(0);
            idle_gap();
        end
    endtask

    // Response side: random stalls, plus a long hold when requested.
    initial
    begin
        rsp_t got;
        rsp.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (rsp_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
                rsp_hold = 1'b0;
            end
            rsp.ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got = '{chte_pkg::status_t'(rsp.status), rsp.found_value, rsp.entry_count};
                if (pending.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected response %h", got);
                end
                else
                begin
                    checked++;
                    if (got != pending[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: status exp %0d got %0d, value exp %h got %h, count exp %0d got %0d",
                                     pending[0].status, got.status, pending[0].found, got.found,
                                     pending[0].count, got.count);
                    end
                    void'(pending.pop_front());
                end
            end
        end
    end

    row_t rows[$];
    initial
    begin
        logic [63:0] ones;
        ones = '1;
        errors = 0; checked = 0; n_full = 0; n_dup = 0; n_absent = 0;
        rsp_hold = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0; req.op = '0; req.key = '0; req.value = '0;
        cfg.valid = 1'b0; cfg.data = '0;
        table_clear();
        ent_key[0] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes and every code; expected responses typed where obvious.
        rows.push_back('{chte_pkg::OP_LOOKUP, 64'd0, 32'd0, 1'b1,
                         '{chte_pkg::STAT_ABSENT, 32'd0, 11'd0}});
        rows.push_back('{chte_pkg::OP_REMOVE, ones, 32'd0, 1'b1,
                         '{chte_pkg::STAT_ABSENT, 32'd0, 11'd0}});
        rows.push_back('{chte_pkg::OP_NOP, ones, '1, 1'b1,
                         '{chte_pkg::STAT_DONE, 32'd0, 11'd0}});
        rows.push_back('{chte_pkg::OP_INSERT, 64'd0, '1, 1'b1,
                         '{chte_pkg::STAT_DONE, 32'd0, 11'd1}});
        rows.push_back('{chte_pkg::OP_INSERT, ones, 32'd0, 1'b1,
                         '{chte_pkg::STAT_DONE, 32'd0, 11'd2}});
        rows.push_back('{chte_pkg::OP_INSERT, 64'd0, 32'd5, 1'b1,
                         '{chte_pkg::STAT_DUP, 32'd0, 11'd2}});
        rows.push_back('{chte_pkg::OP_LOOKUP, 64'd0, 32'd0, 1'b1,
                         '{chte_pkg::STAT_DONE, 32'hFFFF_FFFF, 11'd2}});
        rows.push_back('{chte_pkg::OP_LOOKUP, ones, '1, 1'b1,
                         '{chte_pkg::STAT_DONE, 32'd0, 11'd2}});
        rows.push_back('{chte_pkg::OP_INSERT, 64'h0100, 32'h1234, 1'b0, '0});
        rows.push_back('{chte_pkg::OP_INSERT, 64'h0001, 32'h5678, 1'b0, '0});
        rows.push_back('{chte_pkg::OP_REMOVE, 64'h0100, 32'd0, 1'b0, '0});
        rows.push_back('{chte_pkg::OP_LOOKUP, 64'h0001, 32'd0, 1'b0, '0});
        rows.push_back('{chte_pkg::OP_NOP, 64'd0, 32'd0, 1'b0, '0});
        rows.push_back('{chte_pkg::OP_REMOVE, 64'd0, 32'd0, 1'b0, '0});
        rows.push_back('{chte_pkg::OP_REMOVE, ones, 32'd0, 1'b0, '0});
        rows.push_back('{chte_pkg::OP_REMOVE, 64'h0001, 32'd0, 1'b0, '0});
        foreach (rows[i])
        begin
            send_word(rows[i].op, rows[i].key, rows[i].value, rows[i].want, rows[i].typed);
            idle_gap();
        end
        drain();

        // Count zero acts as one bucket; count above the table saturates.
        write_buckets(10'd0);
        random_words(40, 0);
        drain();
        write_buckets(10'h3FF);
        random_words(40, 0);
        // Long response hold while requests keep coming.
        rsp_hold = 1'b1;
        random_words(30, 0);
        drain();
        // Change count with entries held, then probe them.
        write_buckets(10'd7);
        random_words(40, 40);
        drain();
        write_buckets(10'd1);
        random_words(30, 16);
        drain();
        write_buckets(10'd512);
        random_words(40, 0);
        drain();
        // Fill the pool with distinct keys, then try inserts on a full table.
        write_buckets(10'd509);
        while (held < NENT)
        begin
            send_word(chte_pkg::OP_INSERT, {$urandom, $urandom}, $urandom, '0, 1'b0);
            if ($urandom_range(0, 15) == 0) idle_gap();
        end
        send_word(chte_pkg::OP_INSERT, {$urandom, $urandom}, 32'd1, '0, 1'b0);
        send_word(chte_pkg::OP_INSERT, live_keys[live_keys.size() - 1], 32'd1, '0, 1'b0);
        random_words(30, 0);
        drain();

        $display("covered %0d responses: %0d duplicate, %0d absent, %0d table-full",
                 checked, n_dup, n_absent, n_full);
        $display("bucket counts 0, 1, 7, 509, 512 and 1023, a full pool and a long stall");
        if (errors == 0 && pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ files.f @@
rtl/chte_pkg.sv
rtl/chte_if.sv
rtl/chte_ctrl.sv
rtl/chte_datapath.sv
rtl/chained_hash_table_engine.sv
tb/sv/tb_chte_if.sv
tb/sv/tb.sv
